// ===== design/bda_pkg.sv =====
// Shared constants, types and helper functions for the button debounce and activity block.
`default_nettype none
package bda_pkg;

   // Default parameter values.
   localparam int DEF_BUTTONS      = 3;
   localparam int DEF_HISTORY_BITS = 8;
   localparam int DEF_TIME_BITS    = 32;

   // Fixed widths of the stream and register fields.
   localparam int FIELD_BITS      = 3;
   localparam int NOW_BITS        = 32;
   localparam int TIMEOUT_BITS    = 8;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 8;
   localparam int REQ_DATA_BITS   = 40;
   localparam int RSP_DATA_BITS   = 8;

   // Request tdata layout.
   localparam int PRESSED_LSB = 0;
   localparam int NOW_LSB     = PRESSED_LSB + FIELD_BITS;

   // Response tdata layout.
   localparam int EVENT_LSB  = 0;
   localparam int HELD_LSB   = EVENT_LSB + FIELD_BITS;
   localparam int ACTIVE_BIT = HELD_LSB + FIELD_BITS;
   localparam int RSP_USED   = ACTIVE_BIT + 1;

   // Debounce thresholds.
   localparam int HIST_BITS_MAX    = 16;
   localparam int ONES_BITS        = 5;
   localparam int PRESS_MIN_ONES   = 4;
   localparam int RELEASE_MAX_ONES = 4;
   localparam int WAKE_HISTORY     = 4;

   // Timeout scaling: one unit is five seconds of milliseconds.
   localparam int UNIT_SECONDS  = 5;
   localparam int MS_PER_SECOND = 1000;
   localparam int MS_PER_UNIT   = UNIT_SECONDS * MS_PER_SECOND;
   localparam int LIMIT_BITS    = 21;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_HANDLER_MASK  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLEEP_TIMEOUT = 1'd1;

   // Request kinds carried on tuser.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_WAKE   = 1'b1;

   // What one button lane reports for the current transfer.
   typedef struct packed {
      logic press_event;
      logic held;
      logic recent;
   } lane_out_type;

   // Count the ones in a history word.
   function automatic logic [ONES_BITS-1:0] ones_in(input logic [HIST_BITS_MAX-1:0] value);
      logic [ONES_BITS-1:0] count;
      count = '0;
      for (int i = 0; i < HIST_BITS_MAX; i++) begin
         count = count + ONES_BITS'(value[i]);
      end
      return count;
   endfunction

endpackage
`default_nettype wire

// ===== design/bda_lane.sv =====
// One button lane: history shift register, press and handled latches, press timestamp.
`default_nettype none
module bda_lane #(
   parameter int HISTORY_BITS = bda_pkg::DEF_HISTORY_BITS,
   parameter int TIME_BITS    = bda_pkg::DEF_TIME_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic                            wake,
   input  wire logic                            pressed,
   input  wire logic                            enable,
   input  wire logic [TIME_BITS-1:0]            now,
   input  wire logic [bda_pkg::LIMIT_BITS-1:0]  limit,
   output bda_pkg::lane_out_type                res
);
   import bda_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic                    latched_ff, latched_in;
   logic                    done_ff, done_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;

   logic [HISTORY_BITS-1:0] hist_shift;
   logic [ONES_BITS-1:0]    ones;
   logic                    stamp;
   logic                    event_fire;
   logic [TIME_BITS-1:0]    age;

   assign hist_shift = {hist_ff[HISTORY_BITS-2:0], pressed};
   assign ones       = ones_in(HIST_BITS_MAX'(hist_shift));

   // Next lane state for this transfer.
   always_comb begin
      hist_in    = hist_ff;
      latched_in = latched_ff;
      done_in    = done_ff;
      stamp      = 1'b0;
      event_fire = 1'b0;
      if (wake) begin
         hist_in    = HISTORY_BITS'(WAKE_HISTORY);
         latched_in = 1'b1;
         done_in    = 1'b1;
         stamp      = 1'b1;
      end else begin
         hist_in = hist_shift;
         if (pressed) begin
            if (ones >= ONES_BITS'(PRESS_MIN_ONES)) begin
               if (!latched_ff) begin
                  latched_in = 1'b1;
                  stamp      = 1'b1;
               end
               if (!done_ff && enable) begin
                  done_in    = 1'b1;
                  event_fire = 1'b1;
               end
            end
         end else if (ones <= ONES_BITS'(RELEASE_MAX_ONES)) begin
            latched_in = 1'b0;
            done_in    = 1'b0;
         end
      end
      time_in = stamp ? now : time_ff;
   end

   // A fresh stamp has age zero; otherwise age the stored timestamp.
   assign age = now - time_ff;

   always_comb begin
      res.press_event = event_fire;
      res.held        = latched_in;
      res.recent      = stamp || (CMP_BITS'(age) < CMP_BITS'(limit));
   end

   // Lane state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         latched_ff <= 1'b0;
         done_ff    <= 1'b0;
         time_ff    <= '0;
      end else if (fire) begin
         hist_ff    <= hist_in;
         latched_ff <= latched_in;
         done_ff    <= done_in;
         time_ff    <= time_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/bda_merge.sv =====
// Merge stage: combines the lane reports into one response and holds it in the output register.
`default_nettype none
module bda_merge #(
   parameter int BUTTONS = bda_pkg::DEF_BUTTONS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               fire,
   input  wire logic                               always_active,
   input  wire bda_pkg::lane_out_type              lane_res [BUTTONS],
   output logic                                    in_ready,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output logic [bda_pkg::RSP_DATA_BITS-1:0]       out_data
);
   import bda_pkg::*;

   logic [FIELD_BITS-1:0]    events;
   logic [FIELD_BITS-1:0]    held;
   logic                     active;
   logic                     valid_ff, valid_in;
   logic [RSP_DATA_BITS-1:0] data_ff, data_in;

   // Only the first few buttons appear in the response fields.
   for (genvar b = 0; b < FIELD_BITS; b++) begin : g_field
      if (b < BUTTONS) begin : g_lane
         assign events[b] = lane_res[b].press_event;
         assign held[b]   = lane_res[b].held;
      end else begin : g_none
         assign events[b] = 1'b0;
         assign held[b]   = 1'b0;
      end
   end

   // Active when the timeout is disabled or any lane saw a recent press.
   always_comb begin
      active = always_active;
      for (int b = 0; b < BUTTONS; b++) begin
         active = active | lane_res[b].recent;
      end
   end

   // A new transfer can enter whenever the output register is empty or draining.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fire) begin
         valid_in = 1'b1;
         data_in  = {{(RSP_DATA_BITS - RSP_USED){1'b0}}, active, held, events};
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== design/button_debounce_activity.sv =====
// Top level: three-button history-count debouncer with press events and an activity flag.
// A response is registered in the cycle after its request transfer.
// Throughput: one request per cycle while responses are taken; the output register lets the
// next request in while the current response drains.
// Reset clears every lane's history, latches and timestamp, the handler mask and the
// timeout; there is no clearing pass, so requests are taken from the first cycle after reset.
`default_nettype none
module button_debounce_activity #(
   parameter int BUTTONS      = bda_pkg::DEF_BUTTONS,
   parameter int HISTORY_BITS = bda_pkg::DEF_HISTORY_BITS,
   parameter int TIME_BITS    = bda_pkg::DEF_TIME_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [bda_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // pressed_now[2:0], now_ms[34:3]
   input  wire logic                                req_tuser,  // mode
   // Response stream.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [bda_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,  // press_event[2:0], held[5:3],
                                                                // active[6]
   // Register write port.
   input  wire logic                                csr_we,
   input  wire logic [bda_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [bda_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bda_pkg::*;

   logic [FIELD_BITS-1:0] mask_ff, mask_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   logic                  fire;
   logic                  wake;
   logic [FIELD_BITS-1:0] pressed_now;
   logic [TIME_BITS-1:0]  now_t;
   lane_out_type          lane_res [BUTTONS];

   // Register writes; the timeout is kept prescaled to milliseconds.
   always_comb begin
      mask_in  = mask_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_HANDLER_MASK:  mask_in  = csr_wdata[FIELD_BITS-1:0];
            REG_SLEEP_TIMEOUT: limit_in = LIMIT_BITS'(csr_wdata[TIMEOUT_BITS-1:0])
                                          * LIMIT_BITS'(MS_PER_UNIT);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         limit_ff <= '0;
      end else begin
         mask_ff  <= mask_in;
         limit_ff <= limit_in;
      end
   end

   // Request unpacking.
   assign fire        = req_tvalid && req_tready;
   assign wake        = (req_tuser == MODE_WAKE);
   assign pressed_now = req_tdata[PRESSED_LSB +: FIELD_BITS];

   if (TIME_BITS <= NOW_BITS) begin : g_now_narrow
      assign now_t = req_tdata[NOW_LSB +: TIME_BITS];
   end else begin : g_now_wide
      assign now_t = {{(TIME_BITS - NOW_BITS){1'b0}}, req_tdata[NOW_LSB +: NOW_BITS]};
   end

   // One lane per button; buttons beyond the field width never sample pressed nor fire.
   for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
      logic lane_pressed;
      logic lane_enable;
      if (b < FIELD_BITS) begin : g_mapped
         assign lane_pressed = pressed_now[b];
         assign lane_enable  = mask_ff[b];
      end else begin : g_unmapped
         assign lane_pressed = 1'b0;
         assign lane_enable  = 1'b0;
      end

      bda_lane #(
         .HISTORY_BITS (HISTORY_BITS),
         .TIME_BITS    (TIME_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .fire    (fire),
         .wake    (wake),
         .pressed (lane_pressed),
         .enable  (lane_enable),
         .now     (now_t),
         .limit   (limit_ff),
         .res     (lane_res[b])
      );
   end

   // Merge the lanes and register the response.
   bda_merge #(
      .BUTTONS (BUTTONS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .always_active (limit_ff == '0),
      .lane_res      (lane_res),
      .in_ready      (req_tready),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp_tdata)
   );

endmodule
`default_nettype wire
